// ===== hdl/crptos_pkg.sv =====
package crptos_pkg;

   // fixed field widths of the ports
   localparam int DRAW_BITS      = 40;
   localparam int DISC_BITS      = 16;
   localparam int CMD_BITS       = 2;
   localparam int IDX_IN_BITS    = 9;
   localparam int STATUS_BITS    = 2;
   localparam int OUT_OCC_BITS   = 9;
   localparam int OUT_COUNT_BITS = 24;
   localparam int APB_ADDR_BITS  = 3;
   localparam int APB_DATA_BITS  = 32;

   // register index, taken from paddr[2]
   localparam logic REG_DISCOUNT = 1'b0;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_SEAT_OLD = 2'd0,
      CMD_SEAT_NEW = 2'd1,
      CMD_REMOVE   = 2'd2,
      CMD_READ     = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_BEYOND  = 2'd1,
      ST_OCC_OVF = 2'd2,
      ST_CNT_OVF = 2'd3
   } status_type;

   typedef struct packed {
      logic start;
      logic active;
      logic seat;
   } walk_ctl_type;

   typedef struct packed {
      logic hit;
      logic last;
   } walk_res_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

// ===== hdl/crp_table_occupancy_sampler_unit.sv =====
// seat at old table and remove first walk the histogram, which reads one memory entry per
//   cycle, to choose a table, then update the entries of that table
// seat at new table and read entry go through read, check and result (seat writes back at check)
// one item is in work at a time; the next is taken once the result is in the output register
// reset clears the totals and the discount, then a clearing pass zeroes every entry of
//   the histogram memory; req_stall stays high until it ends
module crp_table_occupancy_sampler_unit #(
   parameter int MAX_OCCUPANCY = 256,
   parameter int COUNT_BITS    = 24,
   parameter int FRAC_BITS     = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // request channel
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [crptos_pkg::CMD_BITS-1:0]             req_command,
   input  logic signed [crptos_pkg::DRAW_BITS-1:0]     req_draw_value,
   input  logic [crptos_pkg::IDX_IN_BITS-1:0]          req_occupancy_index,
   // result channel
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [crptos_pkg::STATUS_BITS-1:0]          rsp_status,
   output logic [crptos_pkg::OUT_OCC_BITS-1:0]         rsp_new_occupancy,
   output logic [crptos_pkg::OUT_COUNT_BITS-1:0]       rsp_total_customers,
   output logic [crptos_pkg::OUT_COUNT_BITS-1:0]       rsp_total_tables,
   output logic                                        rsp_is_empty,
   output logic [crptos_pkg::OUT_COUNT_BITS-1:0]       rsp_entry_count,
   // register port
   input  logic                                        psel,
   input  logic                                        penable,
   input  logic                                        pwrite,
   input  logic [crptos_pkg::APB_ADDR_BITS-1:0]        paddr,
   input  logic [crptos_pkg::APB_DATA_BITS-1:0]        pwdata,
   output logic [crptos_pkg::APB_DATA_BITS-1:0]        prdata,
   output logic                                        pready
);
   import crptos_pkg::*;

   localparam int OCC_BITS = $clog2(MAX_OCCUPANCY + 1);
   localparam int IDX_BITS = $clog2(MAX_OCCUPANCY);

   // discount register, Q0.16
   logic [DISC_BITS-1:0]            discount_ff, discount_in;
   logic [DISC_BITS+FRAC_BITS-1:0]  disc_wide;
   logic [FRAC_BITS-1:0]            disc_scaled;
   logic                            csr_write;

   // between sequencer, walk datapath and histogram memory
   walk_ctl_type                    walk_ctl;
   walk_res_type                    walk_res;
   logic signed [DRAW_BITS-1:0]     rem_init;
   logic [OCC_BITS-1:0]             walk_occ;
   logic [COUNT_BITS-1:0]           walk_count;
   logic                            feed_valid;
   logic [OCC_BITS-1:0]             feed_occ;
   mem_ctl_type                     mem_ctl;
   logic [IDX_BITS-1:0]             rd_addr;
   logic [IDX_BITS-1:0]             wr_addr;
   logic [COUNT_BITS-1:0]           wr_data;
   logic [COUNT_BITS-1:0]           rd_data;

   // register access: no wait states, write lands at the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      discount_in = discount_ff;
      if (csr_write && (paddr[2] == REG_DISCOUNT)) begin
         discount_in = pwdata[DISC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         discount_ff <= '0;
      end else begin
         discount_ff <= discount_in;
      end
   end

   // the address beyond the discount register reads as zero
   assign prdata = (paddr[2] == REG_DISCOUNT) ? APB_DATA_BITS'(discount_ff) : '0;

   // discount rescaled from 16 fraction bits to FRAC_BITS (shift up, or truncate)
   assign disc_wide   = {discount_ff, {FRAC_BITS{1'b0}}};
   assign disc_scaled = disc_wide[FRAC_BITS+DISC_BITS-1:DISC_BITS];

   // sequencer: clearing pass, walk issue, read-modify-write of the chosen entries,
   // totals and the output register
   crptos_ctrl #(
      .MAX_OCCUPANCY (MAX_OCCUPANCY),
      .COUNT_BITS    (COUNT_BITS),
      .FRAC_BITS     (FRAC_BITS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_draw_value      (req_draw_value),
      .req_occupancy_index (req_occupancy_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_new_occupancy   (rsp_new_occupancy),
      .rsp_total_customers (rsp_total_customers),
      .rsp_total_tables    (rsp_total_tables),
      .rsp_is_empty        (rsp_is_empty),
      .rsp_entry_count     (rsp_entry_count),
      .walk_ctl            (walk_ctl),
      .rem_init            (rem_init),
      .walk_res            (walk_res),
      .walk_occ            (walk_occ),
      .walk_count          (walk_count),
      .feed_valid          (feed_valid),
      .feed_occ            (feed_occ),
      .mem_ctl             (mem_ctl),
      .rd_addr             (rd_addr),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data),
      .rd_data             (rd_data)
   );

   // walk pipeline: weight times count registered, then compare and subtract
   // against the remaining draw, one histogram entry per cycle
   crptos_walk_dp #(
      .MAX_OCCUPANCY (MAX_OCCUPANCY),
      .COUNT_BITS    (COUNT_BITS),
      .FRAC_BITS     (FRAC_BITS)
   ) u_walk_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (walk_ctl),
      .rem_init   (rem_init),
      .disc       (disc_scaled),
      .feed_valid (feed_valid),
      .feed_count (rd_data),
      .feed_occ   (feed_occ),
      .res        (walk_res),
      .occ        (walk_occ),
      .count      (walk_count)
   );

   // histogram: entry k holds the number of tables seating k+1 customers
   crptos_hist_mem #(
      .DEPTH (MAX_OCCUPANCY),
      .WIDTH (COUNT_BITS)
   ) u_hist_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule

// ===== hdl/crptos_hist_mem.sv =====
module crptos_hist_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 24,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  crptos_pkg::mem_ctl_type   ctl,
   input  logic [ADDR_BITS-1:0]      rd_addr,
   input  logic [ADDR_BITS-1:0]      wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   output logic [WIDTH-1:0]          rd_data
);
   import crptos_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/crptos_walk_dp.sv =====
module crptos_walk_dp #(
   parameter int MAX_OCCUPANCY = 256,
   parameter int COUNT_BITS    = 24,
   parameter int FRAC_BITS     = 16,
   localparam int OCC_BITS     = $clog2(MAX_OCCUPANCY + 1)
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  crptos_pkg::walk_ctl_type                       ctl,
   input  logic signed [crptos_pkg::DRAW_BITS-1:0]        rem_init,
   input  logic [FRAC_BITS-1:0]                           disc,
   input  logic                                           feed_valid,
   input  logic [COUNT_BITS-1:0]                          feed_count,
   input  logic [OCC_BITS-1:0]                            feed_occ,
   output crptos_pkg::walk_res_type                       res,
   output logic [OCC_BITS-1:0]                            occ,
   output logic [COUNT_BITS-1:0]                          count
);
   import crptos_pkg::*;

   localparam int W_BITS   = OCC_BITS + FRAC_BITS;
   localparam int P_BITS   = COUNT_BITS + W_BITS;
   localparam int CMP_BITS = ((P_BITS > DRAW_BITS) ? P_BITS : DRAW_BITS) + 1;

   logic                          seat_ff;
   logic                          valid_ff;
   logic [P_BITS-1:0]             prod_ff;
   logic [COUNT_BITS-1:0]         cnt_ff;
   logic [OCC_BITS-1:0]           occ_ff;
   logic signed [DRAW_BITS-1:0]   rem_ff;

   logic [W_BITS-1:0]             weight;
   logic signed [CMP_BITS-1:0]    rem_ext;
   logic signed [CMP_BITS-1:0]    prod_ext;
   logic signed [CMP_BITS-1:0]    diff;
   logic                          nonzero;
   logic                          covers;

   // weight of one table: occupancy minus discount, or plain occupancy
   always_comb begin
      if (seat_ff) begin
         weight = {feed_occ, {FRAC_BITS{1'b0}}} - W_BITS'(disc);
      end else begin
         weight = W_BITS'(feed_occ);
      end
   end

   assign rem_ext  = CMP_BITS'(rem_ff);
   assign prod_ext = $signed(CMP_BITS'(prod_ff));
   assign diff     = rem_ext - prod_ext;
   assign nonzero  = (cnt_ff != '0);
   assign covers   = (prod_ext >= rem_ext);

   assign res.hit  = valid_ff && nonzero && covers;
   assign res.last = valid_ff && (occ_ff == OCC_BITS'(MAX_OCCUPANCY));
   assign occ      = occ_ff;
   assign count    = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.start) begin
         valid_ff <= 1'b0;
      end else if (ctl.active) begin
         valid_ff <= feed_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff  <= rem_init;
         seat_ff <= ctl.seat;
      end else if (ctl.active) begin
         if (valid_ff && nonzero && !covers) begin
            rem_ff <= $signed(diff[DRAW_BITS-1:0]);
         end
         if (feed_valid) begin
            prod_ff <= P_BITS'(feed_count) * P_BITS'(weight);
            cnt_ff  <= feed_count;
            occ_ff  <= feed_occ;
         end
      end
   end

endmodule

// ===== hdl/crptos_ctrl.sv =====
module crptos_ctrl #(
   parameter int MAX_OCCUPANCY = 256,
   parameter int COUNT_BITS    = 24,
   parameter int FRAC_BITS     = 16,
   localparam int OCC_BITS     = $clog2(MAX_OCCUPANCY + 1),
   localparam int IDX_BITS     = $clog2(MAX_OCCUPANCY)
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [crptos_pkg::CMD_BITS-1:0]             req_command,
   input  logic signed [crptos_pkg::DRAW_BITS-1:0]     req_draw_value,
   input  logic [crptos_pkg::IDX_IN_BITS-1:0]          req_occupancy_index,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [crptos_pkg::STATUS_BITS-1:0]          rsp_status,
   output logic [crptos_pkg::OUT_OCC_BITS-1:0]         rsp_new_occupancy,
   output logic [crptos_pkg::OUT_COUNT_BITS-1:0]       rsp_total_customers,
   output logic [crptos_pkg::OUT_COUNT_BITS-1:0]       rsp_total_tables,
   output logic                                        rsp_is_empty,
   output logic [crptos_pkg::OUT_COUNT_BITS-1:0]       rsp_entry_count,
   output crptos_pkg::walk_ctl_type                    walk_ctl,
   output logic signed [crptos_pkg::DRAW_BITS-1:0]     rem_init,
   input  crptos_pkg::walk_res_type                    walk_res,
   input  logic [OCC_BITS-1:0]                         walk_occ,
   input  logic [COUNT_BITS-1:0]                       walk_count,
   output logic                                        feed_valid,
   output logic [OCC_BITS-1:0]                         feed_occ,
   output crptos_pkg::mem_ctl_type                     mem_ctl,
   output logic [IDX_BITS-1:0]                         rd_addr,
   output logic [IDX_BITS-1:0]                         wr_addr,
   output logic [COUNT_BITS-1:0]                       wr_data,
   input  logic [COUNT_BITS-1:0]                       rd_data
);
   import crptos_pkg::*;

   localparam int CIDX_BITS = (OCC_BITS > IDX_IN_BITS) ? OCC_BITS : IDX_IN_BITS;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_WALK   = 7'b0000100,
      S_READ   = 7'b0001000,
      S_CHECK  = 7'b0010000,
      S_WRITE2 = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [OCC_BITS-1:0]          issue_ff, issue_in;
   logic                         pend_ff, pend_in;
   logic [OCC_BITS-1:0]          tag_ff, tag_in;
   cmd_type                      cmd_ff, cmd_in;
   logic [OCC_BITS-1:0]          occ_sel_ff, occ_sel_in;
   logic [COUNT_BITS-1:0]        cnt_sel_ff, cnt_sel_in;
   logic [IDX_BITS-1:0]          fix_addr_ff, fix_addr_in;
   status_type                   st_ff, st_in;
   logic [OCC_BITS-1:0]          newocc_ff, newocc_in;
   logic [COUNT_BITS-1:0]        entry_ff, entry_in;
   logic [COUNT_BITS-1:0]        cust_ff, cust_in;
   logic [COUNT_BITS-1:0]        tab_ff, tab_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   status_type                   rsp_status_ff, rsp_status_in;
   logic [OUT_OCC_BITS-1:0]      rsp_newocc_ff, rsp_newocc_in;
   logic [OUT_COUNT_BITS-1:0]    rsp_cust_ff, rsp_cust_in;
   logic [OUT_COUNT_BITS-1:0]    rsp_tab_ff, rsp_tab_in;
   logic                         rsp_empty_ff, rsp_empty_in;
   logic [OUT_COUNT_BITS-1:0]    rsp_entry_ff, rsp_entry_in;

   logic                         accept;
   cmd_type                      req_cmd;
   logic [CIDX_BITS-1:0]         idx_wide;
   logic                         idx_ok;
   logic signed [DRAW_BITS-1:0]  rank;
   logic                         entry_full;
   logic                         cust_full;
   logic                         tab_full;

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign req_cmd    = cmd_type'(req_command);
   assign idx_wide   = CIDX_BITS'(req_occupancy_index);
   assign idx_ok     = (idx_wide != '0) && (idx_wide <= CIDX_BITS'(MAX_OCCUPANCY));
   assign entry_full = (rd_data == {COUNT_BITS{1'b1}});
   assign cust_full  = (cust_ff == {COUNT_BITS{1'b1}});
   assign tab_full   = (tab_ff == {COUNT_BITS{1'b1}});

   // integer rank for remove, floored and clamped at zero
   assign rank = req_draw_value[DRAW_BITS-1] ? '0 :
                 $signed({{FRAC_BITS{1'b0}}, req_draw_value[DRAW_BITS-1:FRAC_BITS]});
   assign rem_init = (req_cmd == CMD_REMOVE) ? rank : req_draw_value;

   assign feed_valid = pend_ff;
   assign feed_occ   = tag_ff;

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      tag_in        = tag_ff;
      cmd_in        = cmd_ff;
      occ_sel_in    = occ_sel_ff;
      cnt_sel_in    = cnt_sel_ff;
      fix_addr_in   = fix_addr_ff;
      st_in         = st_ff;
      newocc_in     = newocc_ff;
      entry_in      = entry_ff;
      cust_in       = cust_ff;
      tab_in        = tab_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_newocc_in = rsp_newocc_ff;
      rsp_cust_in   = rsp_cust_ff;
      rsp_tab_in    = rsp_tab_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_entry_in  = rsp_entry_ff;
      walk_ctl      = '0;
      mem_ctl       = '0;
      rd_addr       = fix_addr_ff;
      wr_addr       = fix_addr_ff;
      wr_data       = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = issue_ff[IDX_BITS-1:0];
            issue_in      = issue_ff + OCC_BITS'(1);
            if (issue_ff == OCC_BITS'(MAX_OCCUPANCY - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_cmd;
               st_in     = ST_OK;
               newocc_in = '0;
               entry_in  = '0;
               issue_in  = '0;
               unique case (req_cmd)
                  CMD_SEAT_OLD, CMD_REMOVE: begin
                     walk_ctl.start = 1'b1;
                     walk_ctl.seat  = (req_cmd == CMD_SEAT_OLD);
                     state_in       = S_WALK;
                  end
                  CMD_SEAT_NEW: begin
                     fix_addr_in = '0;
                     state_in    = S_READ;
                  end
                  CMD_READ: begin
                     if (idx_ok) begin
                        fix_addr_in = IDX_BITS'(idx_wide - CIDX_BITS'(1));
                        state_in    = S_READ;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
               endcase
            end
         end
         S_WALK: begin
            walk_ctl.active = 1'b1;
            // stream one entry a cycle into the weight pipeline
            if (issue_ff != OCC_BITS'(MAX_OCCUPANCY)) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = issue_ff[IDX_BITS-1:0];
               issue_in      = issue_ff + OCC_BITS'(1);
               pend_in       = 1'b1;
               tag_in        = issue_ff + OCC_BITS'(1);
            end
            if (walk_res.hit) begin
               occ_sel_in = walk_occ;
               cnt_sel_in = walk_count;
               if (cmd_ff == CMD_SEAT_OLD) begin
                  if (walk_occ == OCC_BITS'(MAX_OCCUPANCY)) begin
                     st_in    = ST_OCC_OVF;
                     state_in = S_FINISH;
                  end else begin
                     // entry of the next occupancy up
                     fix_addr_in = walk_occ[IDX_BITS-1:0];
                     state_in    = S_READ;
                  end
               end else if (walk_occ == OCC_BITS'(1)) begin
                  // single-customer table leaves
                  cust_in   = cust_ff - COUNT_BITS'(1);
                  tab_in    = tab_ff - COUNT_BITS'(1);
                  newocc_in = '0;
                  state_in  = S_WRITE2;
               end else begin
                  fix_addr_in = IDX_BITS'(walk_occ - OCC_BITS'(2));
                  state_in    = S_READ;
               end
            end else if (walk_res.last) begin
               st_in    = ST_BEYOND;
               state_in = S_FINISH;
            end
         end
         S_READ: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            unique case (cmd_ff)
               CMD_SEAT_OLD: begin
                  if (cust_full || entry_full) begin
                     st_in    = ST_CNT_OVF;
                     state_in = S_FINISH;
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     wr_data       = rd_data + COUNT_BITS'(1);
                     cust_in       = cust_ff + COUNT_BITS'(1);
                     newocc_in     = occ_sel_ff + OCC_BITS'(1);
                     state_in      = S_WRITE2;
                  end
               end
               CMD_SEAT_NEW: begin
                  if (cust_full || tab_full || entry_full) begin
                     st_in    = ST_CNT_OVF;
                     state_in = S_FINISH;
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     wr_data       = rd_data + COUNT_BITS'(1);
                     cust_in       = cust_ff + COUNT_BITS'(1);
                     tab_in        = tab_ff + COUNT_BITS'(1);
                     newocc_in     = OCC_BITS'(1);
                     state_in      = S_FINISH;
                  end
               end
               CMD_REMOVE: begin
                  if (entry_full) begin
                     st_in    = ST_CNT_OVF;
                     state_in = S_FINISH;
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     wr_data       = rd_data + COUNT_BITS'(1);
                     cust_in       = cust_ff - COUNT_BITS'(1);
                     newocc_in     = occ_sel_ff - OCC_BITS'(1);
                     state_in      = S_WRITE2;
                  end
               end
               CMD_READ: begin
                  entry_in = rd_data;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_WRITE2: begin
            // the chosen table leaves its old occupancy
            mem_ctl.wr_en = 1'b1;
            wr_addr       = IDX_BITS'(occ_sel_ff - OCC_BITS'(1));
            wr_data       = cnt_sel_ff - COUNT_BITS'(1);
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_newocc_in = OUT_OCC_BITS'(newocc_ff);
               rsp_cust_in   = OUT_COUNT_BITS'(cust_ff);
               rsp_tab_in    = OUT_COUNT_BITS'(tab_ff);
               rsp_empty_in  = (cust_ff == '0);
               rsp_entry_in  = OUT_COUNT_BITS'(entry_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         cust_ff      <= '0;
         tab_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         cust_ff      <= cust_in;
         tab_ff       <= tab_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff        <= tag_in;
      cmd_ff        <= cmd_in;
      occ_sel_ff    <= occ_sel_in;
      cnt_sel_ff    <= cnt_sel_in;
      fix_addr_ff   <= fix_addr_in;
      st_ff         <= st_in;
      newocc_ff     <= newocc_in;
      entry_ff      <= entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_newocc_ff <= rsp_newocc_in;
      rsp_cust_ff   <= rsp_cust_in;
      rsp_tab_ff    <= rsp_tab_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_new_occupancy   = rsp_newocc_ff;
   assign rsp_total_customers = rsp_cust_ff;
   assign rsp_total_tables    = rsp_tab_ff;
   assign rsp_is_empty        = rsp_empty_ff;
   assign rsp_entry_count     = rsp_entry_ff;

endmodule

// ===== hdl/crptos_checker.sv =====
module crptos_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [crptos_pkg::STATUS_BITS-1:0]     rsp_status,
   input logic [crptos_pkg::OUT_OCC_BITS-1:0]    rsp_new_occupancy,
   input logic [crptos_pkg::OUT_COUNT_BITS-1:0]  rsp_total_customers,
   input logic [crptos_pkg::OUT_COUNT_BITS-1:0]  rsp_total_tables,
   input logic                                   rsp_is_empty,
   input logic [crptos_pkg::OUT_COUNT_BITS-1:0]  rsp_entry_count
);
   import crptos_pkg::*;

   // one item in work at a time
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in work");

   // every table seats at least one customer
   a_tables_le_customers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_total_tables <= rsp_total_customers))
      else $error("more tables than customers");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_total_customers == '0)))
      else $error("empty flag disagrees with customer total");

   // an error result carries no occupancy and no entry count
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_new_occupancy == '0) && (rsp_entry_count == '0))
      else $error("error result with nonzero fields");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_total_customers))
      else $error("stalled result changed");

endmodule

bind crp_table_occupancy_sampler_unit crptos_checker u_crptos_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_new_occupancy   (rsp_new_occupancy),
   .rsp_total_customers (rsp_total_customers),
   .rsp_total_tables    (rsp_total_tables),
   .rsp_is_empty        (rsp_is_empty),
   .rsp_entry_count     (rsp_entry_count)
);

// ===== tb/sv/tb.sv =====
module tb;
   import crptos_pkg::*;

   // block sizing, as built
   localparam int MAX_OCC    = 256;
   localparam int FRAC_BITS  = 16;
   localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;
   // longest walk plus write-back and output register
   localparam int LATENCY    = MAX_OCC + 8;
   localparam logic [APB_ADDR_BITS-1:0] DISCOUNT_ADDR = {REG_DISCOUNT, 2'b00};

   typedef longint unsigned u64_t;

   // one result transfer as the block should present it
   typedef struct packed {
      status_type  status;
      logic [8:0]  occupancy;
      logic [23:0] customers;
      logic [23:0] tables;
      logic        empty;
      logic [23:0] entry;
   } seating_outcome_t;

   // one row of the opening sequence; want only counts when typed is set
   typedef struct packed {
      cmd_type          cmd;
      logic [39:0]      draw;
      logic [8:0]       index;
      logic             typed;
      seating_outcome_t want;
   } probe_row_t;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [CMD_BITS-1:0] req_command;
   logic signed [DRAW_BITS-1:0] req_draw_value;
   logic [IDX_IN_BITS-1:0] req_occupancy_index;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [OUT_OCC_BITS-1:0] rsp_new_occupancy;
   logic [OUT_COUNT_BITS-1:0] rsp_total_customers;
   logic [OUT_COUNT_BITS-1:0] rsp_total_tables;
   logic rsp_is_empty;
   logic [OUT_COUNT_BITS-1:0] rsp_entry_count;
   logic psel;
   logic penable;
   logic pwrite;
   logic [APB_ADDR_BITS-1:0] paddr;
   logic [APB_DATA_BITS-1:0] pwdata;
   logic [APB_DATA_BITS-1:0] prdata;
   logic pready;

   // predictor state: tables per occupancy (entry k is occupancy k+1) and totals
   logic [23:0] occ_hist [MAX_OCC];
   logic [23:0] seated;
   logic [23:0] table_count;
   logic [15:0] discount_q;

   seating_outcome_t pending_outcomes [$];
   // typed expectation travelling with the request currently on the bus
   logic             req_typed;
   seating_outcome_t req_fixed;
   int               fails = 0;
   // no idling on either side while set
   bit               steady = 1'b0;
   int               stall_left = 0;

   // opening sequence: empty restaurant, field extremes, every command, draws beyond the total
   probe_row_t probe_rows [21] = '{
      '{CMD_READ,     40'h00_0000_0000, 9'd0,   1'b1,
        '{ST_OK,      9'd0, 24'd0, 24'd0, 1'b1, 24'd0}},
      '{CMD_SEAT_OLD, 40'h00_0000_0000, 9'd0,   1'b1,
        '{ST_BEYOND,  9'd0, 24'd0, 24'd0, 1'b1, 24'd0}},
      '{CMD_REMOVE,   40'h00_0000_0000, 9'd0,   1'b1,
        '{ST_BEYOND,  9'd0, 24'd0, 24'd0, 1'b1, 24'd0}},
      '{CMD_READ,     40'h00_0000_0000, 9'd256, 1'b1,
        '{ST_OK,      9'd0, 24'd0, 24'd0, 1'b1, 24'd0}},
      '{CMD_READ,     40'h00_0000_0000, 9'd511, 1'b1,
        '{ST_OK,      9'd0, 24'd0, 24'd0, 1'b1, 24'd0}},
      '{CMD_SEAT_NEW, 40'h00_0000_0000, 9'd0,   1'b1,
        '{ST_OK,      9'd1, 24'd1, 24'd1, 1'b0, 24'd0}},
      '{CMD_SEAT_NEW, 40'h7F_FFFF_FFFF, 9'd0,   1'b1,
        '{ST_OK,      9'd1, 24'd2, 24'd2, 1'b0, 24'd0}},
      '{CMD_SEAT_OLD, 40'h80_0000_0000, 9'd0,   1'b1,
        '{ST_OK,      9'd2, 24'd3, 24'd2, 1'b0, 24'd0}},
      '{CMD_READ,     40'h00_0000_0000, 9'd1,   1'b1,
        '{ST_OK,      9'd0, 24'd3, 24'd2, 1'b0, 24'd1}},
      '{CMD_READ,     40'h00_0000_0000, 9'd2,   1'b1,
        '{ST_OK,      9'd0, 24'd3, 24'd2, 1'b0, 24'd1}},
      '{CMD_SEAT_OLD, 40'h7F_FFFF_FFFF, 9'd0,   1'b1,
        '{ST_BEYOND,  9'd0, 24'd3, 24'd2, 1'b0, 24'd0}},
      '{CMD_REMOVE,   40'h7F_FFFF_FFFF, 9'd0,   1'b1,
        '{ST_BEYOND,  9'd0, 24'd3, 24'd2, 1'b0, 24'd0}},
      '{CMD_REMOVE,   40'h80_0000_0000, 9'h1FF, 1'b1,
        '{ST_OK,      9'd0, 24'd2, 24'd1, 1'b0, 24'd0}},
      '{CMD_SEAT_OLD, 40'h00_0001_0000, 9'd0,   1'b0, '0},
      '{CMD_SEAT_NEW, 40'h00_0000_0000, 9'd0,   1'b0, '0},
      '{CMD_SEAT_OLD, 40'h00_0004_0000, 9'd0,   1'b0, '0},
      '{CMD_SEAT_OLD, 40'h00_0006_0001, 9'd0,   1'b0, '0},
      '{CMD_REMOVE,   40'h00_0002_FFFF, 9'd0,   1'b0, '0},
      '{CMD_REMOVE,   40'hFF_FFFF_FFFF, 9'd0,   1'b0, '0},
      '{CMD_READ,     40'h00_0000_0000, 9'd3,   1'b0, '0},
      '{CMD_READ,     40'h00_0000_0000, 9'd4,   1'b0, '0}
   };

   crp_table_occupancy_sampler_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_draw_value      (req_draw_value),
      .req_occupancy_index (req_occupancy_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_new_occupancy   (rsp_new_occupancy),
      .rsp_total_customers (rsp_total_customers),
      .rsp_total_tables    (rsp_total_tables),
      .rsp_is_empty        (rsp_is_empty),
      .rsp_entry_count     (rsp_entry_count),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

   // walk the histogram in ascending occupancy; 0 when the draw runs past the total
   // seat weighs each table by occupancy minus discount (fixed point), remove by occupancy
   function automatic int unsigned walk_histogram(longint rem, bit seat);
      u64_t cnt, w, ur, need;
      for (int occ = 1; occ <= MAX_OCC; occ++) begin
         cnt = u64_t'(occ_hist[occ-1]);
         if (cnt == 0)
            continue;
         if (rem <= 0)
            return occ;
         w = seat ? ((u64_t'(occ) << FRAC_BITS) - u64_t'(discount_q)) : u64_t'(occ);
         ur = u64_t'(rem);
         need = (ur + w - 1) / w;
         if (cnt >= need)
            return occ;
         rem = longint'(ur - cnt * w);
      end
      return 0;
   endfunction

   // total weight of every seated table, in draw units for seat and in whole customers for remove
   function automatic u64_t histogram_weight(bit seat);
      u64_t sum;
      sum = 0;
      for (int occ = 1; occ <= MAX_OCC; occ++)
         sum += u64_t'(occ_hist[occ-1]) *
                (seat ? ((u64_t'(occ) << FRAC_BITS) - u64_t'(discount_q)) : u64_t'(occ));
      return sum;
   endfunction

   // apply one request to the predictor state and give back the result it should produce
   function automatic seating_outcome_t restaurant_step(cmd_type c, logic [39:0] raw,
                                                        logic [8:0] idx);
      seating_outcome_t res;
      longint draw, rank;
      int unsigned o;
      res = '0;
      res.status = ST_OK;
      draw = longint'($signed(raw));
      case (c)
         CMD_SEAT_OLD: begin
            o = walk_histogram(draw, 1'b1);
            if (o == 0)
               res.status = ST_BEYOND;
            else if (o >= MAX_OCC)
               res.status = ST_OCC_OVF;
            else if (seated >= COUNT_MAX || occ_hist[o] >= COUNT_MAX)
               res.status = ST_CNT_OVF;
            else begin
               seated = seated + 1;
               occ_hist[o] = occ_hist[o] + 1;
               occ_hist[o-1] = occ_hist[o-1] - 1;
               res.occupancy = 9'(o + 1);
            end
         end
         CMD_SEAT_NEW: begin
            if (seated >= COUNT_MAX || table_count >= COUNT_MAX || occ_hist[0] >= COUNT_MAX)
               res.status = ST_CNT_OVF;
            else begin
               seated = seated + 1;
               table_count = table_count + 1;
               occ_hist[0] = occ_hist[0] + 1;
               res.occupancy = 9'd1;
            end
         end
         CMD_REMOVE: begin
            // rank is the integer part of the draw, negatives count as zero
            rank = (draw < 0) ? 0 : (draw >>> FRAC_BITS);
            o = walk_histogram(rank, 1'b0);
            if (o == 0)
               res.status = ST_BEYOND;
            else if (o > 1 && occ_hist[o-2] >= COUNT_MAX)
               res.status = ST_CNT_OVF;
            else begin
               seated = seated - 1;
               if (o == 1)
                  table_count = table_count - 1;
               else
                  occ_hist[o-2] = occ_hist[o-2] + 1;
               occ_hist[o-1] = occ_hist[o-1] - 1;
               res.occupancy = 9'(o - 1);
            end
         end
         default: begin
            if (idx >= 1 && idx <= MAX_OCC)
               res.entry = occ_hist[idx-1];
         end
      endcase
      res.customers = seated;
      res.tables = table_count;
      res.empty = (seated == 0);
      return res;
   endfunction

   // mostly short idle runs, now and then a long one
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic cmd_type pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25)
         return CMD_SEAT_NEW;
      if (r < 60)
         return CMD_SEAT_OLD;
      if (r < 85)
         return CMD_REMOVE;
      return CMD_READ;
   endfunction

   // draws aimed at the live total: inside it, on its edges, negative, or anywhere
   function automatic logic [39:0] pick_draw(cmd_type c);
      u64_t total, unit;
      bit seat;
      int r;
      seat = (c == CMD_SEAT_OLD);
      total = seat ? histogram_weight(1'b1) : (histogram_weight(1'b0) << FRAC_BITS);
      unit = seat ? 64'd1 : (64'd1 << FRAC_BITS);
      r = $urandom_range(0, 99);
      if (r < 60)
         return 40'({$urandom, $urandom} % (total + 2));
      if (r < 75)
         return 40'(total + unit * $urandom_range(0, 2) - unit);
      if (r < 88)
         return 40'(-longint'($urandom_range(1, 32'hFFFF_FFFF)));
      return 40'({$urandom, $urandom});
   endfunction

   function automatic logic [8:0] pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 9'($urandom_range(0, 12));
      if (r < 85)
         return 9'($urandom_range(250, 260));
      return 9'($urandom_range(0, 511));
   endfunction

   // result stall pattern, changed on the falling edge
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!steady && $urandom_range(0, 99) < 30) begin
         stall_left <= idle_span() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // rising edge: check the result transfer first, then predict the accepted request
   always @(posedge clock) begin : tally_check
      seating_outcome_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("result transfer with nothing outstanding");
            fails++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fails++;
            end
            if (rsp_new_occupancy !== want.occupancy) begin
               $error("new_occupancy: expected %0d, got %0d", want.occupancy,
                      rsp_new_occupancy);
               fails++;
            end
            if (rsp_total_customers !== want.customers) begin
               $error("total_customers: expected %0d, got %0d", want.customers,
                      rsp_total_customers);
               fails++;
            end
            if (rsp_total_tables !== want.tables) begin
               $error("total_tables: expected %0d, got %0d", want.tables, rsp_total_tables);
               fails++;
            end
            if (rsp_is_empty !== want.empty) begin
               $error("is_empty: expected %0d, got %0d", want.empty, rsp_is_empty);
               fails++;
            end
            if (rsp_entry_count !== want.entry) begin
               $error("entry_count: expected %0d, got %0d", want.entry, rsp_entry_count);
               fails++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         // predictor always runs so its state follows the block, typed rows override
         want = restaurant_step(cmd_type'(req_command), req_draw_value, req_occupancy_index);
         pending_outcomes.push_back(req_typed ? req_fixed : want);
      end
   end

   // present one request after a random gap, return at the edge that accepts it
   task automatic offer_request(cmd_type c, logic [39:0] d, logic [8:0] idx,
                                logic typed = 1'b0, seating_outcome_t fixed = '0);
      int gap;
      @(negedge clock);
      gap = (!steady && $urandom_range(0, 99) < 40) ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= c;
      req_draw_value <= d;
      req_occupancy_index <= idx;
      req_typed <= typed;
      req_fixed <= fixed;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // sender goes quiet until every outstanding result has been seen
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(negedge clock);
   endtask

   // drained and past any walk still in flight
   task automatic settle();
      hold_until_drained();
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic csr_write(logic [APB_ADDR_BITS-1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_read(logic [APB_ADDR_BITS-1:0] addr, output logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      data = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // new discount while idle, read it back, then a run of random requests
   task automatic run_phase(logic [31:0] disc_word, int count, bit calm);
      cmd_type c;
      logic [31:0] back;
      settle();
      csr_write(DISCOUNT_ADDR, disc_word);
      discount_q = disc_word[15:0];
      csr_read(DISCOUNT_ADDR, back);
      if (back[15:0] !== disc_word[15:0]) begin
         $error("discount: expected %0h, got %0h", disc_word[15:0], back[15:0]);
         fails++;
      end
      steady = calm;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) == 0)
            hold_until_drained();
         c = pick_command();
         offer_request(c, pick_draw(c), pick_index());
      end
   endtask

   // empty the restaurant, then grow one table to the occupancy ceiling and past it
   task automatic climb_to_ceiling();
      logic [39:0] d;
      steady = 1'b0;
      while (seated != 0) begin
         d = 40'((u64_t'($urandom_range(0, seated)) << FRAC_BITS) | $urandom_range(0, 16'hFFFF));
         offer_request(CMD_REMOVE, d, pick_index());
      end
      offer_request(CMD_SEAT_NEW, pick_draw(CMD_SEAT_NEW), pick_index());
      repeat (MAX_OCC - 1) begin
         d = 40'({$urandom, $urandom} % (histogram_weight(1'b1) + 1));
         offer_request(CMD_SEAT_OLD, d, pick_index());
      end
      // table at the ceiling: one more seat must be refused
      offer_request(CMD_SEAT_OLD, 40'd0, 9'd0);
      offer_request(CMD_READ, 40'd0, 9'(MAX_OCC));
      repeat (3) offer_request(CMD_SEAT_NEW, pick_draw(CMD_SEAT_NEW), pick_index());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_READ;
      req_draw_value = '0;
      req_occupancy_index = '0;
      req_typed = 1'b0;
      req_fixed = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      foreach (occ_hist[k])
         occ_hist[k] = '0;
      seated = '0;
      table_count = '0;
      discount_q = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // opening sequence at the reset discount of zero
      foreach (probe_rows[k])
         offer_request(probe_rows[k].cmd, probe_rows[k].draw, probe_rows[k].index,
                       probe_rows[k].typed, probe_rows[k].want);

      // discount settings: both extremes, half, one LSB and random words, two quiet stretches
      run_phase(32'h0000_FFFF, 150, 1'b0);
      run_phase(32'h0000_0000, 150, 1'b1);
      climb_to_ceiling();
      run_phase(32'h0000_8000, 170, 1'b0);
      run_phase($urandom, 170, 1'b0);
      run_phase(32'h0000_0001, 150, 1'b0);
      run_phase($urandom, 150, 1'b1);

      settle();
      if (fails == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
